FILE: design/hla_pkg.sv
// Shared types, codes, widths and the sine table for the Hough line accumulator.
`default_nettype none

package hla_pkg;

    // Defaults of the top-level parameters
    localparam int IMAGE_DIM_DEF      = 512;
    localparam int ANGLE_BINS_DEF     = 180;
    localparam int RHO_BINS_DEF       = 1448;
    localparam int COUNT_BITS_DEF     = 18;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // Fixed field widths
    localparam int CMD_W = 2;
    localparam int PIX_W = 9;
    localparam int VAL_W = 8;
    localparam int ROW_W = 11;
    localparam int ANG_W = 8;
    localparam int THR_W = 18;
    localparam int OFF_W = 10;
    localparam int IDX_W = 2;

    localparam int TABLE_FRAC_BITS = 14;
    localparam int ANGLE_SHIFT     = 90;

    localparam logic [VAL_W-1:0] EDGE_VALUE = 8'd255;
    localparam logic [THR_W-1:0] THR_RESET  = 18'd100;
    localparam logic [OFF_W-1:0] OFF_RESET  = 10'd724;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_VOTE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CLR = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET    = 2'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

    // One transaction travelling down the row of cells
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [ROW_W-1:0] ri;
        logic [ANG_W-1:0] ai;
    } t_token;

    // round(sin(k degrees) * 2^14), k = 0..90
    function automatic int sin_q14(input int k);
        int v;
        case (k)
            0: v = 0;          1: v = 286;        2: v = 572;        3: v = 857;
            4: v = 1143;       5: v = 1428;       6: v = 1713;       7: v = 1997;
            8: v = 2280;       9: v = 2563;       10: v = 2845;      11: v = 3126;
            12: v = 3406;      13: v = 3686;      14: v = 3964;      15: v = 4240;
            16: v = 4516;      17: v = 4790;      18: v = 5063;      19: v = 5334;
            20: v = 5604;      21: v = 5872;      22: v = 6138;      23: v = 6402;
            24: v = 6664;      25: v = 6924;      26: v = 7182;      27: v = 7438;
            28: v = 7692;      29: v = 7943;      30: v = 8192;      31: v = 8438;
            32: v = 8682;      33: v = 8923;      34: v = 9162;      35: v = 9397;
            36: v = 9630;      37: v = 9860;      38: v = 10087;     39: v = 10311;
            40: v = 10531;     41: v = 10749;     42: v = 10963;     43: v = 11174;
            44: v = 11381;     45: v = 11585;     46: v = 11786;     47: v = 11982;
            48: v = 12176;     49: v = 12365;     50: v = 12551;     51: v = 12733;
            52: v = 12911;     53: v = 13085;     54: v = 13255;     55: v = 13421;
            56: v = 13583;     57: v = 13741;     58: v = 13894;     59: v = 14044;
            60: v = 14189;     61: v = 14330;     62: v = 14466;     63: v = 14598;
            64: v = 14726;     65: v = 14849;     66: v = 14968;     67: v = 15082;
            68: v = 15191;     69: v = 15296;     70: v = 15396;     71: v = 15491;
            72: v = 15582;     73: v = 15668;     74: v = 15749;     75: v = 15826;
            76: v = 15897;     77: v = 15964;     78: v = 16026;     79: v = 16083;
            80: v = 16135;     81: v = 16182;     82: v = 16225;     83: v = 16262;
            84: v = 16294;     85: v = 16322;     86: v = 16344;     87: v = 16362;
            88: v = 16374;     89: v = 16382;     90: v = 16384;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Table entry rescaled to frac fraction bits, rounding half up when narrowing
    function automatic int trig_mag(input int k, input int frac);
        int v;
        int sh;
        v = sin_q14(k);
        if (frac < TABLE_FRAC_BITS) begin
            sh = TABLE_FRAC_BITS - frac;
            return (v + (1 << (sh - 1))) >>> sh;
        end
        return v << (frac - TABLE_FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

FILE: design/hough_line_accumulator.sv
// Top level of the Hough line voting accumulator: control, configuration and the cell row.
//
// Input channel (i_in_valid / o_in_stall) takes one transaction: a vote for a
// pixel (command 0), a cell read (1) or a cell read-and-clear (2). Only reads
// produce a result on the output channel (o_out_valid / i_out_stall).
// A row of ANGLE_BINS cells, one per angle, each owns a RHO_BINS-deep column
// of saturating counters. A transaction steps one cell per cycle; each cell
// computes its rho and does a read-modify-write on its own column in the
// registered stages behind it, and a read's count rides a result lane to
// the end of the row. A vote or read that enters the row keeps the block busy,
// with the input stalled, until it has drained through the cell row and the
// cell's read-modify-write pipe. Non-edge or out-of-image votes and unused
// commands are taken and dropped without making the block busy.
// Reset: registers return to their reset values and a clearing pass zeroes
// every column, one row per cycle in all cells at once, while the input is
// stalled; configuration writes are always taken.
// A stalled output holds its transaction; one more result can wait in a hold
// register, and the input stalls until that hold register is empty.
`default_nettype none

module hough_line_accumulator #(
    parameter int IMAGE_DIM      = hla_pkg::IMAGE_DIM_DEF,
    parameter int ANGLE_BINS     = hla_pkg::ANGLE_BINS_DEF,
    parameter int RHO_BINS       = hla_pkg::RHO_BINS_DEF,
    parameter int COUNT_BITS     = hla_pkg::COUNT_BITS_DEF,
    parameter int TRIG_FRAC_BITS = hla_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [hla_pkg::CMD_W-1:0]     i_command,
    input  wire [hla_pkg::PIX_W-1:0]     i_pixel_x,
    input  wire [hla_pkg::PIX_W-1:0]     i_pixel_y,
    input  wire [hla_pkg::VAL_W-1:0]     i_pixel_value,
    input  wire [hla_pkg::ROW_W-1:0]     i_rho_index,
    input  wire [hla_pkg::ANG_W-1:0]     i_angle_index,
    // output channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic signed [hla_pkg::ROW_W-1:0] o_rho_signed,
    output logic signed [hla_pkg::ANG_W-1:0] o_angle_deg,
    output logic [COUNT_BITS-1:0]        o_vote_count,
    output logic                         o_is_peak,
    // configuration write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [hla_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire [hla_pkg::THR_W-1:0]     i_cfg_data
);

    localparam int RW       = $clog2(RHO_BINS);
    localparam int DRAIN    = ANGLE_BINS + 4;
    localparam int CNT_W    = $clog2(DRAIN);
    localparam int TOK_LEFT = DRAIN - 1 - ANGLE_BINS;

    hla_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [RW-1:0]    r_clr_addr;

    logic [hla_pkg::THR_W-1:0] r_thr;
    logic [hla_pkg::OFF_W-1:0] r_offset;

    hla_pkg::t_token           r_tok;
    logic [hla_pkg::ROW_W-1:0] r_ri;
    logic [hla_pkg::ANG_W-1:0] r_ai;

    logic                          r_out_vld, r_hold_vld;
    logic [hla_pkg::ROW_W-1:0]     r_out_rho, r_hold_rho;
    logic [hla_pkg::ANG_W-1:0]     r_out_ang, r_hold_ang;
    logic [COUNT_BITS-1:0]         r_out_cnt, r_hold_cnt;
    logic                          r_out_pk, r_hold_pk;

    hla_pkg::t_token       w_tok [ANGLE_BINS+1];
    logic                  w_res_hit [ANGLE_BINS+1];
    logic [COUNT_BITS-1:0] w_res_count [ANGLE_BINS+1];
    logic                  w_res_vld [ANGLE_BINS];

    logic w_clr_en, w_in_acc, w_edge, w_inject, w_clr_last;
    logic w_out_free, w_tail_vld;
    logic [hla_pkg::ROW_W-1:0] w_t_rho;
    logic [hla_pkg::ANG_W-1:0] w_t_ang;
    logic [COUNT_BITS-1:0]     w_t_cnt;
    logic                      w_t_pk;

    // ---------------- accept and classify ----------------
    always_comb begin
        w_in_acc   = i_in_valid && !o_in_stall;
        w_edge     = (i_pixel_value == hla_pkg::EDGE_VALUE) &&
                     (32'(i_pixel_x) < 32'(IMAGE_DIM)) &&
                     (32'(i_pixel_y) < 32'(IMAGE_DIM));
        // Only edge votes and reads enter the row; everything else is dropped
        w_inject   = w_in_acc &&
                     ((i_command == hla_pkg::CMD_VOTE && w_edge) ||
                      i_command == hla_pkg::CMD_READ ||
                      i_command == hla_pkg::CMD_READ_CLR);
        w_clr_last = (r_clr_addr == RW'(RHO_BINS - 1));
    end

    // ---------------- control state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            hla_pkg::ST_CLEAR: begin
                if (w_clr_last) n_state = hla_pkg::ST_IDLE;
            end
            hla_pkg::ST_IDLE: begin
                if (w_inject) n_state = hla_pkg::ST_BUSY;
            end
            hla_pkg::ST_BUSY: begin
                if (r_cnt == '0) n_state = hla_pkg::ST_IDLE;
            end
            default: n_state = hla_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_clr_en   = 1'b0;
        case (r_state)
            hla_pkg::ST_CLEAR: w_clr_en   = 1'b1;
            hla_pkg::ST_IDLE:  o_in_stall = r_hold_vld;
            hla_pkg::ST_BUSY:  o_in_stall = 1'b1;
            default:           o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hla_pkg::ST_CLEAR;
            r_cnt      <= '0;
            r_clr_addr <= '0;
            r_tok      <= '0;
        end else begin
            r_state <= n_state;
            if (w_inject) begin
                r_cnt <= CNT_W'(DRAIN - 1);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_clr_en) r_clr_addr <= r_clr_addr + 1'b1;
            r_tok.valid <= w_inject;
            r_tok.cmd   <= i_command;
            r_tok.px    <= i_pixel_x;
            r_tok.py    <= i_pixel_y;
            r_tok.ri    <= i_rho_index;
            r_tok.ai    <= i_angle_index;
        end
    end

    // Hold the read coordinates for the result; one transaction in flight at a time
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ri <= i_rho_index;
            r_ai <= i_angle_index;
        end
    end

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= hla_pkg::THR_RESET;
            r_offset <= hla_pkg::OFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hla_pkg::REG_THRESHOLD: r_thr    <= i_cfg_data;
                hla_pkg::REG_OFFSET:    r_offset <= i_cfg_data[hla_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- row of angle cells ----------------
    assign w_tok[0]       = r_tok;
    assign w_res_hit[0]   = 1'b0;
    assign w_res_count[0] = '0;

    for (genvar k = 0; k < ANGLE_BINS; k++) begin : g_cell
        hla_cell #(
            .ANGLE          (k),
            .RHO_BINS       (RHO_BINS),
            .COUNT_BITS     (COUNT_BITS),
            .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (w_tok[k]),
            .o_tok       (w_tok[k+1]),
            .i_offset    (r_offset),
            .i_clr_en    (w_clr_en),
            .i_clr_addr  (r_clr_addr),
            .i_res_hit   (w_res_hit[k]),
            .i_res_count (w_res_count[k]),
            .o_res_vld   (w_res_vld[k]),
            .o_res_hit   (w_res_hit[k+1]),
            .o_res_count (w_res_count[k+1])
        );
    end

    // ---------------- result formation ----------------
    always_comb begin
        w_tail_vld = w_res_vld[ANGLE_BINS-1];
        w_t_rho    = r_ri - hla_pkg::ROW_W'(r_offset);
        w_t_ang    = r_ai - hla_pkg::ANG_W'(hla_pkg::ANGLE_SHIFT);
        w_t_cnt    = w_res_count[ANGLE_BINS];
        // Out-of-range reads carry no hit, so never flag a peak for them
        w_t_pk     = w_res_hit[ANGLE_BINS] && (32'(w_t_cnt) >= 32'(r_thr));
        w_out_free = !r_out_vld || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld  <= r_hold_vld || w_tail_vld;
            r_hold_vld <= r_hold_vld && w_tail_vld;
        end else if (w_tail_vld) begin
            r_hold_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_hold_vld) begin
                r_out_rho <= r_hold_rho;
                r_out_ang <= r_hold_ang;
                r_out_cnt <= r_hold_cnt;
                r_out_pk  <= r_hold_pk;
            end else begin
                r_out_rho <= w_t_rho;
                r_out_ang <= w_t_ang;
                r_out_cnt <= w_t_cnt;
                r_out_pk  <= w_t_pk;
            end
        end
        if (w_tail_vld && (r_hold_vld || !w_out_free)) begin
            r_hold_rho <= w_t_rho;
            r_hold_ang <= w_t_ang;
            r_hold_cnt <= w_t_cnt;
            r_hold_pk  <= w_t_pk;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_rho_signed = $signed(r_out_rho);
    assign o_angle_deg  = $signed(r_out_ang);
    assign o_vote_count = r_out_cnt;
    assign o_is_peak    = r_out_pk;

    // ---------------- assertions ----------------
    a_tok_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[ANGLE_BINS].valid |->
            (r_state == hla_pkg::ST_BUSY) && (r_cnt == CNT_W'(TOK_LEFT)))
        else $error("transaction left the cell row at the wrong time");

    a_tail_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_vld |-> (r_state == hla_pkg::ST_BUSY) && (r_cnt == '0))
        else $error("read result arrived outside the drain window");

    a_hold_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_vld |-> !r_hold_vld)
        else $error("read result arrived with the hold register full");

    a_hold_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hold_vld) |-> $past(r_out_vld && i_out_stall))
        else $error("hold register filled while the output was free");

    a_no_clear_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_en |-> o_in_stall)
        else $error("input taken during the clearing pass");

endmodule

`default_nettype wire

FILE: design/hla_cell.sv
// One angle cell: rho computation, its own accumulator column and a result lane stage.
`default_nettype none

module hla_cell #(
    parameter int ANGLE          = 0,
    parameter int RHO_BINS       = hla_pkg::RHO_BINS_DEF,
    parameter int COUNT_BITS     = hla_pkg::COUNT_BITS_DEF,
    parameter int TRIG_FRAC_BITS = hla_pkg::TRIG_FRAC_BITS_DEF,
    localparam int RW            = $clog2(RHO_BINS)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire hla_pkg::t_token  i_tok,
    output hla_pkg::t_token       o_tok,
    input  wire [hla_pkg::OFF_W-1:0] i_offset,
    input  wire                   i_clr_en,
    input  wire [RW-1:0]          i_clr_addr,
    input  wire                   i_res_hit,
    input  wire [COUNT_BITS-1:0]  i_res_count,
    output logic                  o_res_vld,
    output logic                  o_res_hit,
    output logic [COUNT_BITS-1:0] o_res_count
);

    localparam int THETA = ANGLE - hla_pkg::ANGLE_SHIFT;
    localparam int MAG   = (THETA < 0) ? -THETA : THETA;
    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int PW    = TW + hla_pkg::PIX_W + 1;
    localparam int AW    = PW + 1;
    localparam int C_VAL = hla_pkg::trig_mag(hla_pkg::ANGLE_SHIFT - MAG, TRIG_FRAC_BITS);
    localparam int S_MAG = hla_pkg::trig_mag(MAG, TRIG_FRAC_BITS);
    localparam logic signed [TW-1:0] C_Q = TW'(C_VAL);
    localparam logic signed [TW-1:0] S_Q = (THETA < 0) ? TW'(-S_MAG) : TW'(S_MAG);
    localparam logic signed [AW-1:0] BIAS_POS = AW'(1 << (TRIG_FRAC_BITS - 1));
    localparam logic signed [AW-1:0] BIAS_NEG = AW'((1 << (TRIG_FRAC_BITS - 1)) - 1);
    localparam logic signed [AW:0]   RHO_LIM  = (AW + 1)'(RHO_BINS);
    localparam logic [hla_pkg::ANG_W-1:0] ANGLE_CODE = hla_pkg::ANG_W'(ANGLE);

    hla_pkg::t_token r_tok;

    logic                 r_s1_vote, r_s1_any, r_s1_sel, r_s1_clr;
    logic [RW-1:0]        r_s1_raddr;
    logic signed [PW-1:0] r_pc, r_ps;

    logic                 r_s2_vote, r_s2_any, r_s2_sel, r_s2_clr;
    logic [RW-1:0]        r_s2_addr;

    logic                 r_s3_vote, r_s3_any, r_s3_sel, r_s3_clr;
    logic [RW-1:0]        r_s3_addr;
    logic [COUNT_BITS-1:0] r_rd;

    logic [COUNT_BITS-1:0] r_mem [RHO_BINS];

    logic                  r_res_vld, r_res_hit;
    logic [COUNT_BITS-1:0] r_res_count;

    logic                  w_rd_any, w_sel;
    logic [31:0]           w_ri_ext;
    logic signed [AW-1:0]  w_acc, w_sum, w_rho;
    logic signed [AW:0]    w_idx;
    logic                  w_vote_ok;
    logic [COUNT_BITS-1:0] w_inc;

    // Select the read target: this column and a row inside the store
    always_comb begin
        w_ri_ext = 32'(i_tok.ri);
        w_rd_any = i_tok.valid &&
                   (i_tok.cmd == hla_pkg::CMD_READ || i_tok.cmd == hla_pkg::CMD_READ_CLR);
        w_sel    = w_rd_any && (i_tok.ai == ANGLE_CODE) && (w_ri_ext < 32'(RHO_BINS));
    end

    // Round half away from zero as floor((acc + half - neg) / 2^F)
    always_comb begin
        w_acc     = AW'(r_pc) + AW'(r_ps);
        w_sum     = w_acc + (w_acc[AW-1] ? BIAS_NEG : BIAS_POS);
        w_rho     = w_sum >>> TRIG_FRAC_BITS;
        w_idx     = (AW + 1)'(w_rho) + (AW + 1)'($signed({1'b0, i_offset}));
        w_vote_ok = r_s1_vote && !w_idx[AW] && (w_idx < RHO_LIM);
        w_inc     = (r_rd == {COUNT_BITS{1'b1}}) ? r_rd : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok     <= '0;
            r_s1_vote <= 1'b0;
            r_s1_any  <= 1'b0;
            r_s1_sel  <= 1'b0;
            r_s1_clr  <= 1'b0;
            r_s2_vote <= 1'b0;
            r_s2_any  <= 1'b0;
            r_s2_sel  <= 1'b0;
            r_s2_clr  <= 1'b0;
            r_s3_vote <= 1'b0;
            r_s3_any  <= 1'b0;
            r_s3_sel  <= 1'b0;
            r_s3_clr  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_tok     <= i_tok;
            r_s1_vote <= i_tok.valid && (i_tok.cmd == hla_pkg::CMD_VOTE);
            r_s1_any  <= w_rd_any;
            r_s1_sel  <= w_sel;
            r_s1_clr  <= w_sel && (i_tok.cmd == hla_pkg::CMD_READ_CLR);
            r_s2_vote <= w_vote_ok;
            r_s2_any  <= r_s1_any;
            r_s2_sel  <= r_s1_sel;
            r_s2_clr  <= r_s1_clr;
            r_s3_vote <= r_s2_vote;
            r_s3_any  <= r_s2_any;
            r_s3_sel  <= r_s2_sel;
            r_s3_clr  <= r_s2_clr;
            r_res_vld <= r_s3_any;
        end
    end

    // Products, addresses and lane data
    always_ff @(posedge i_clk) begin
        r_s1_raddr  <= w_ri_ext[RW-1:0];
        r_pc        <= $signed({1'b0, i_tok.px}) * C_Q;
        r_ps        <= $signed({1'b0, i_tok.py}) * S_Q;
        r_s2_addr   <= r_s1_vote ? w_idx[RW-1:0] : r_s1_raddr;
        r_s3_addr   <= r_s2_addr;
        r_res_hit   <= r_s3_sel ? 1'b1 : i_res_hit;
        r_res_count <= r_s3_sel ? r_rd : i_res_count;
    end

    // Column store: registered read, one write port for sweep, vote or clear
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_s2_addr];
        if (i_clr_en) begin
            r_mem[i_clr_addr] <= '0;
        end else if (r_s3_vote) begin
            r_mem[r_s3_addr] <= w_inc;
        end else if (r_s3_clr) begin
            r_mem[r_s3_addr] <= '0;
        end
    end

    assign o_tok       = r_tok;
    assign o_res_vld   = r_res_vld;
    assign o_res_hit   = r_res_hit;
    assign o_res_count = r_res_count;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the Hough line voting accumulator.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ANGLES   = 180;
    localparam int N_ROWS     = 1448;
    localparam int COUNT_W    = 18;
    localparam int FRAC       = 14;
    localparam int SETTLE     = 200;
    localparam int HOLD_OFF   = 3000;
    localparam logic [COUNT_W-1:0] COUNT_CEIL = '1;
    localparam logic [hla_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [hla_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

    // sin(k degrees) scaled by 2^14, k = 0..90
    localparam int SIN_DEG [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct {
        logic signed [hla_pkg::ROW_W-1:0] rho;
        logic signed [hla_pkg::ANG_W-1:0] angle;
        logic [COUNT_W-1:0]               count;
        logic                             peak;
    } t_cell_read;

    // Mirror of the accumulator: cell counts, both registers and the reads in flight
    class t_vote_predictor;
        logic [COUNT_W-1:0]        counts [];
        logic [hla_pkg::THR_W-1:0] threshold;
        logic [hla_pkg::OFF_W-1:0] offset;
        t_cell_read                reads_due [$];
        int                        errors;
        int                        reads_seen;
        int                        peaks_seen;

        function new();
            counts = new[N_ROWS * N_ANGLES];
            foreach (counts[k]) counts[k] = '0;
            threshold = hla_pkg::THR_RESET;
            offset = hla_pkg::OFF_RESET;
            errors = 0;
            reads_seen = 0;
            peaks_seen = 0;
        endfunction

        function void write_reg(logic [hla_pkg::IDX_W-1:0] idx,
                                logic [hla_pkg::THR_W-1:0] data);
            if (idx == hla_pkg::REG_THRESHOLD) threshold = data;
            else if (idx == hla_pkg::REG_OFFSET) offset = data[hla_pkg::OFF_W-1:0];
        endfunction

        // Offset row that pixel (x, y) votes for at angle column a
        function int row_of(int x, int y, int a);
            int theta, mag, c, s, acc, rho;
            theta = a - 90;
            mag = (theta < 0) ? -theta : theta;
            c = SIN_DEG[90 - mag];
            s = (theta < 0) ? -SIN_DEG[mag] : SIN_DEG[mag];
            acc = x * c + y * s;
            if (acc >= 0) rho = (acc + (1 << (FRAC - 1))) >>> FRAC;
            else rho = -((-acc + (1 << (FRAC - 1))) >>> FRAC);
            return rho + int'(offset);
        endfunction

        function void note_input(logic [hla_pkg::CMD_W-1:0] cmd,
                                 logic [hla_pkg::PIX_W-1:0] x,
                                 logic [hla_pkg::PIX_W-1:0] y,
                                 logic [hla_pkg::VAL_W-1:0] v,
                                 logic [hla_pkg::ROW_W-1:0] ri,
                                 logic [hla_pkg::ANG_W-1:0] ai);
            t_cell_read r;
            int row, k;
            if (cmd == hla_pkg::CMD_VOTE) begin
                if (v != hla_pkg::EDGE_VALUE) return;
                for (int a = 0; a < N_ANGLES; a++) begin
                    row = row_of(x, y, a);
                    if (row < 0 || row >= N_ROWS) continue;
                    k = row * N_ANGLES + a;
                    if (counts[k] != COUNT_CEIL) counts[k]++;
                end
                return;
            end
            if (cmd == CMD_SPARE) return;
            r.rho = ri - hla_pkg::ROW_W'(offset);
            r.angle = ai - hla_pkg::ANG_W'(hla_pkg::ANGLE_SHIFT);
            r.count = '0;
            r.peak = 1'b0;
            if (ri < N_ROWS && ai < N_ANGLES) begin
                k = int'(ri) * N_ANGLES + int'(ai);
                r.count = counts[k];
                r.peak = (r.count >= threshold);
                if (cmd == hla_pkg::CMD_READ_CLR) counts[k] = '0;
            end
            reads_due.push_back(r);
        endfunction

        function void check_result(t_cell_read got);
            t_cell_read want;
            reads_seen++;
            if (got.peak) peaks_seen++;
            if (reads_due.size() == 0) begin
                $error("unexpected read result: rho %0d angle %0d count %0d",
                       got.rho, got.angle, got.count);
                errors++;
                return;
            end
            want = reads_due.pop_front();
            if (got.rho !== want.rho) begin
                $error("rho_signed: expected %0d, got %0d", want.rho, got.rho);
                errors++;
            end
            if (got.angle !== want.angle) begin
                $error("angle_deg: expected %0d, got %0d", want.angle, got.angle);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("vote_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.peak !== want.peak) begin
                $error("is_peak: expected %0b, got %0b", want.peak, got.peak);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [hla_pkg::CMD_W-1:0]        i_command = hla_pkg::CMD_VOTE;
    logic [hla_pkg::PIX_W-1:0]        i_pixel_x = '0;
    logic [hla_pkg::PIX_W-1:0]        i_pixel_y = '0;
    logic [hla_pkg::VAL_W-1:0]        i_pixel_value = '0;
    logic [hla_pkg::ROW_W-1:0]        i_rho_index = '0;
    logic [hla_pkg::ANG_W-1:0]        i_angle_index = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b1;
    logic signed [hla_pkg::ROW_W-1:0] o_rho_signed;
    logic signed [hla_pkg::ANG_W-1:0] o_angle_deg;
    logic [COUNT_W-1:0]               o_vote_count;
    logic                             o_is_peak;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [hla_pkg::IDX_W-1:0]        i_cfg_index = '0;
    logic [hla_pkg::THR_W-1:0]        i_cfg_data = '0;

    hough_line_accumulator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_pixel_value(i_pixel_value), .i_rho_index(i_rho_index),
        .i_angle_index(i_angle_index),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_rho_signed(o_rho_signed), .o_angle_deg(o_angle_deg),
        .o_vote_count(o_vote_count), .o_is_peak(o_is_peak),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    t_vote_predictor votes = new();

    // Shared knobs: burst mode suppresses idling, hold_off_req asks for a long stall
    bit burst_mode = 1'b0;
    bit hold_off_req = 1'b0;
    int items_sent = 0;
    int edge_votes = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit: far beyond the slowest legal run
    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int idle_draw();
        return burst_mode ? 0 : $urandom_range(0, 15);
    endfunction

    // Offer one input transaction and hold it until the block takes it
    task automatic send_item(logic [hla_pkg::CMD_W-1:0] cmd,
                             logic [hla_pkg::PIX_W-1:0] x,
                             logic [hla_pkg::PIX_W-1:0] y,
                             logic [hla_pkg::VAL_W-1:0] v,
                             logic [hla_pkg::ROW_W-1:0] ri,
                             logic [hla_pkg::ANG_W-1:0] ai);
        int gap;
        gap = idle_draw();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_command = cmd;
        i_pixel_x = x;
        i_pixel_y = y;
        i_pixel_value = v;
        i_rho_index = ri;
        i_angle_index = ai;
        do @(posedge i_clk); while (o_in_stall);
        votes.note_input(cmd, x, y, v, ri, ai);
        items_sent++;
        if (cmd == hla_pkg::CMD_VOTE && v == hla_pkg::EDGE_VALUE) edge_votes++;
    endtask

    // Random filler for every field of one transaction but the command
    task automatic send_random(logic [hla_pkg::CMD_W-1:0] cmd);
        send_item(cmd, hla_pkg::PIX_W'($urandom), hla_pkg::PIX_W'($urandom),
                  hla_pkg::VAL_W'($urandom), hla_pkg::ROW_W'($urandom),
                  hla_pkg::ANG_W'($urandom));
    endtask

    task automatic vote(int x, int y, int v = hla_pkg::EDGE_VALUE);
        send_item(hla_pkg::CMD_VOTE, hla_pkg::PIX_W'(x), hla_pkg::PIX_W'(y),
                  hla_pkg::VAL_W'(v), hla_pkg::ROW_W'($urandom),
                  hla_pkg::ANG_W'($urandom));
    endtask

    task automatic read_cell(logic [hla_pkg::CMD_W-1:0] cmd, int ri, int ai);
        send_item(cmd, hla_pkg::PIX_W'($urandom), hla_pkg::PIX_W'($urandom),
                  hla_pkg::VAL_W'($urandom), hla_pkg::ROW_W'(ri),
                  hla_pkg::ANG_W'(ai));
    endtask

    task automatic write_reg(logic [hla_pkg::IDX_W-1:0] idx,
                             logic [hla_pkg::THR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        votes.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drain every outstanding read, then let a trailing vote finish its sweep
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (votes.reads_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Result side: random stall per transaction, one long hold-off on request
    initial begin
        int gap;
        t_cell_read got;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (HOLD_OFF) @(negedge i_clk);
            end
            gap = idle_draw();
            repeat (gap) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.rho = o_rho_signed;
            got.angle = o_angle_deg;
            got.count = o_vote_count;
            got.peak = o_is_peak;
            votes.check_result(got);
        end
    end

    // One phase of random traffic: hot pixels pile up votes, most reads aim at their cells
    task automatic random_phase(int n_items);
        int hot_x [4];
        int hot_y [4];
        int pick, h, a, row;
        foreach (hot_x[k]) begin
            hot_x[k] = $urandom_range(0, 511);
            hot_y[k] = $urandom_range(0, 511);
        end
        for (int n = 0; n < n_items; n++) begin
            if (n % 97 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            h = $urandom_range(0, 3);
            if (pick < 45) begin
                vote(hot_x[h], hot_y[h]);
            end else if (pick < 55) begin
                send_random(hla_pkg::CMD_VOTE);
            end else if (pick < 85) begin
                a = $urandom_range(0, N_ANGLES - 1);
                row = votes.row_of(hot_x[h], hot_y[h], a);
                if (row < 0 || row >= N_ROWS) row = $urandom_range(0, N_ROWS - 1);
                read_cell(($urandom_range(0, 4) == 0) ? hla_pkg::CMD_READ_CLR
                                                      : hla_pkg::CMD_READ, row, a);
            end else if (pick < 96) begin
                send_random(($urandom_range(0, 1) == 0) ? hla_pkg::CMD_READ
                                                        : hla_pkg::CMD_READ_CLR);
            end else begin
                send_random(CMD_SPARE);
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: image corners, non-edge values, the origin row, bounds of the store
        vote(0, 0);
        vote(511, 511);
        vote(511, 0);
        vote(0, 511);
        vote(511, 511, 254);
        vote(3, 7, 0);
        vote(0, 0);
        read_cell(hla_pkg::CMD_READ, 724, 0);
        read_cell(hla_pkg::CMD_READ_CLR, 724, 90);
        read_cell(hla_pkg::CMD_READ, 724, 90);
        read_cell(hla_pkg::CMD_READ, votes.row_of(511, 511, 135), 135);
        read_cell(hla_pkg::CMD_READ, votes.row_of(511, 0, 0), 0);
        read_cell(hla_pkg::CMD_READ, 0, 179);
        read_cell(hla_pkg::CMD_READ, 1447, 179);
        read_cell(hla_pkg::CMD_READ, 1448, 0);
        read_cell(hla_pkg::CMD_READ, 0, 180);
        read_cell(hla_pkg::CMD_READ_CLR, 2047, 255);
        send_item(CMD_SPARE, 9'd511, 9'd511, 8'd255, 11'd724, 8'd90);
        read_cell(hla_pkg::CMD_READ, 724, 45);
        wait_quiet();

        // Threshold one, offset one: most negative rho votes fall off the store
        write_reg(hla_pkg::REG_THRESHOLD, 18'd1);
        write_reg(hla_pkg::REG_OFFSET, 18'd1);
        vote(0, 511);
        read_cell(hla_pkg::CMD_READ, votes.row_of(0, 511, 0), 0);
        read_cell(hla_pkg::CMD_READ, 1, 90);
        random_phase(330);
        wait_quiet();

        // Threshold zero flags every cell; spare index must be ignored
        write_reg(hla_pkg::REG_THRESHOLD, 18'd0);
        write_reg(REG_SPARE, 18'h3FFFF);
        write_reg(hla_pkg::REG_OFFSET, 18'd362);
        random_phase(330);
        wait_quiet();

        // Top threshold, offset written with all bits set (wraps beyond the store)
        write_reg(hla_pkg::REG_THRESHOLD, 18'h3FFFF);
        write_reg(hla_pkg::REG_OFFSET, 18'h3FFFF);
        random_phase(250);
        wait_quiet();

        // Back to the default geometry; hold the result side off to fill the block
        write_reg(hla_pkg::REG_THRESHOLD, 18'd60);
        write_reg(hla_pkg::REG_OFFSET, 18'd724);
        hold_off_req = 1'b1;
        random_phase(600);
        wait_quiet();

        $display("Covered %0d input transactions (%0d edge votes), %0d reads checked, %0d peaks.",
                 items_sent, edge_votes, votes.reads_seen, votes.peaks_seen);
        $display("Thresholds 0/1/60/max and offsets 1/362/724/1023 were exercised.");
        if (votes.errors == 0 && votes.reads_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/hla_pkg.sv
design/hla_cell.sv
design/hough_line_accumulator.sv
verif/testbench.sv
